[design/ptfa_pkg.sv]
// Shared types and codes for the partition table fit allocator.
// Holds the slot entry type, the cell operation codes, status codes and fit modes.
// No dependencies.
`default_nettype none

package ptfa_pkg;

    localparam int DEFAULT_SLOTS = 4;

    localparam int ADDR_W   = 31;
    localparam int KIND_W   = 2;
    localparam int STATUS_W = 3;
    localparam int COUNT_W  = 3;
    localparam int SLOT_W   = 2;
    localparam int MODE_W   = 2;
    localparam int HDR_W    = 16;
    localparam int CFG_IDX_W = 2;

    // Register indexes of the configuration port
    localparam logic [CFG_IDX_W-1:0] CFG_DISK_SIZE   = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_FIT_MODE    = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_HEADER_SIZE = 2'd2;

    // Fit policies; the unused code behaves as first fit
    localparam logic [MODE_W-1:0] FIT_FIRST = 2'd0;
    localparam logic [MODE_W-1:0] FIT_BEST  = 2'd1;
    localparam logic [MODE_W-1:0] FIT_WORST = 2'd2;

    // Operations
    localparam logic FUNC_ALLOC = 1'b0;
    localparam logic FUNC_FREE  = 1'b1;

    // Region kinds
    localparam logic [KIND_W-1:0] KIND_PRIMARY  = 2'd0;
    localparam logic [KIND_W-1:0] KIND_EXTENDED = 2'd1;
    localparam logic [KIND_W-1:0] KIND_LOGICAL  = 2'd2;

    // Result status codes
    localparam logic [STATUS_W-1:0] ST_OK      = 3'd0;
    localparam logic [STATUS_W-1:0] ST_ZERO    = 3'd1;
    localparam logic [STATUS_W-1:0] ST_FULL    = 3'd2;
    localparam logic [STATUS_W-1:0] ST_EXT2    = 3'd3;
    localparam logic [STATUS_W-1:0] ST_NOEXT   = 3'd4;
    localparam logic [STATUS_W-1:0] ST_NOSPACE = 3'd5;
    localparam logic [STATUS_W-1:0] ST_EMPTY   = 3'd6;

    typedef struct packed {
        logic              valid;
        logic [KIND_W-1:0] kind;
        logic [ADDR_W-1:0] start;
        logic [ADDR_W-1:0] length;
    } entry_t;

    typedef enum logic [1:0] {
        CELL_HOLD,
        CELL_LOAD,
        CELL_FROM_LOWER,
        CELL_FROM_UPPER
    } cell_op_t;

endpackage

`default_nettype wire

[design/ptfa_cell.sv]
// One table slot of the partition table fit allocator.
// Holds an entry and loads a new one or takes its lower or upper neighbor's entry.
// Depends on ptfa_pkg.
`default_nettype none

module ptfa_cell
    import ptfa_pkg::*;
(
    input  wire logic     clk,
    input  wire logic     rst_n,
    input  wire cell_op_t op,
    input  wire entry_t   new_entry,
    input  wire entry_t   lower_entry,
    input  wire entry_t   upper_entry,
    output entry_t        entry
);

    entry_t entry_reg;
    entry_t entry_next;

    always_comb
    begin
        case (op)
            CELL_HOLD:       entry_next = entry_reg;
            CELL_LOAD:       entry_next = new_entry;
            CELL_FROM_LOWER: entry_next = lower_entry;
            CELL_FROM_UPPER: entry_next = upper_entry;
            default:         entry_next = entry_reg;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            entry_reg <= '0;
        end
        else
        begin
            entry_reg <= entry_next;
        end
    end

    assign entry = entry_reg;

endmodule

`default_nettype wire

[design/partition_table_fit_allocator.sv]
// Partition table fit allocator: a chain of slot cells kept sorted by start.
// A free or a rejected allocate goes from the check straight to done; a placed or
// no-space allocate first scans the gaps, one gap per cycle through the scan.
// Throughput: one transaction at a time, busy high until the result is formed.
// Reset clears the table and the registers to zero; results cannot be stalled.
`default_nettype none

module partition_table_fit_allocator
    import ptfa_pkg::*;
#(
    parameter int SLOTS = DEFAULT_SLOTS
)
(
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire logic                 start,
    output logic                      busy,
    input  wire logic                 func,
    input  wire logic [ADDR_W-1:0]    alloc_size,
    input  wire logic [KIND_W-1:0]    region_kind,
    input  wire logic [SLOT_W-1:0]    slot_index,
    output logic                      done,
    output logic [STATUS_W-1:0]       status,
    output logic [ADDR_W-1:0]         start_address,
    output logic [COUNT_W-1:0]        valid_count,
    input  wire logic                 cfg_valid,
    output logic                      cfg_ready,
    input  wire logic [CFG_IDX_W-1:0] cfg_index,
    input  wire logic [ADDR_W-1:0]    cfg_data
);

    localparam int CNT_W = $clog2(SLOTS + 1);

    typedef enum logic [2:0] {
        S_IDLE,
        S_CHECK,
        S_SCAN,
        S_COMMIT,
        S_DONE
    } state_t;

    // Configuration registers
    logic [ADDR_W-1:0] disk_size_reg;
    logic [MODE_W-1:0] fit_mode_reg;
    logic [HDR_W-1:0]  header_size_reg;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            disk_size_reg   <= '0;
            fit_mode_reg    <= '0;
            header_size_reg <= '0;
        end
        else if (cfg_valid && cfg_ready)
        begin
            case (cfg_index)
                CFG_DISK_SIZE:   disk_size_reg   <= cfg_data;
                CFG_FIT_MODE:    fit_mode_reg    <= cfg_data[MODE_W-1:0];
                CFG_HEADER_SIZE: header_size_reg <= cfg_data[HDR_W-1:0];
                default:         ;
            endcase
        end
    end

    // Cell chain
    entry_t   cells [SLOTS];
    cell_op_t cell_op [SLOTS];
    entry_t   new_entry;

    for (genvar k = 0; k < SLOTS; k++)
    begin : g_cell
        entry_t lower;
        entry_t upper;
        if (k == 0)
        begin : g_bottom
            assign lower = '0;
        end
        else
        begin : g_mid_lo
            assign lower = cells[k-1];
        end
        if (k == SLOTS - 1)
        begin : g_top
            assign upper = '0;
        end
        else
        begin : g_mid_hi
            assign upper = cells[k+1];
        end
        ptfa_cell u_cell (
            .clk         (clk),
            .rst_n       (rst_n),
            .op          (cell_op[k]),
            .new_entry   (new_entry),
            .lower_entry (lower),
            .upper_entry (upper),
            .entry       (cells[k])
        );
    end

    // Control registers
    state_t              state_reg,      state_next;
    logic                func_reg,       func_next;
    logic [ADDR_W-1:0]   size_reg,       size_next;
    logic [KIND_W-1:0]   kind_reg,       kind_next;
    logic [SLOT_W-1:0]   slot_reg,       slot_next;
    logic [CNT_W-1:0]    i_reg,          i_next;
    logic [ADDR_W:0]     prev_end_reg,   prev_end_next;
    logic                found_reg,      found_next;
    logic [ADDR_W-1:0]   best_gap_reg,   best_gap_next;
    logic [ADDR_W-1:0]   best_start_reg, best_start_next;
    logic [CNT_W-1:0]    best_pos_reg,   best_pos_next;
    logic [STATUS_W-1:0] status_reg,     status_next;
    logic [ADDR_W-1:0]   start_reg,      start_next;
    logic                done_reg,       done_next;
    logic [COUNT_W-1:0]  count_reg,      count_next;

    // Table summaries
    logic [CNT_W-1:0] used;
    logic             has_ext;
    logic             slot_valid;
    entry_t           scan_entry;

    always_comb
    begin
        used       = '0;
        has_ext    = 1'b0;
        slot_valid = 1'b0;
        scan_entry = '0;
        for (int k = 0; k < SLOTS; k++)
        begin
            used = used + CNT_W'(cells[k].valid);
            if (cells[k].valid && cells[k].kind == KIND_EXTENDED)
            begin
                has_ext = 1'b1;
            end
            if (32'(k) == {30'd0, slot_reg})
            begin
                slot_valid = cells[k].valid;
            end
            if (CNT_W'(k) == i_reg)
            begin
                scan_entry = cells[k];
            end
        end
    end

    // Gap evaluation for the slot under the scan index
    logic              scan_inner;
    logic [ADDR_W:0]   bound;
    logic [ADDR_W:0]   diff;
    logic [ADDR_W-1:0] gap;
    logic              fits;
    logic              take;
    logic [ADDR_W:0]   region_end;

    always_comb
    begin
        scan_inner = (i_reg < used);
        bound      = scan_inner ? {1'b0, scan_entry.start} : {1'b0, disk_size_reg};
        diff       = bound - prev_end_reg;
        gap        = (bound > prev_end_reg) ? diff[ADDR_W-1:0] : '0;
        fits       = (gap >= size_reg);
        take       = !found_reg
                     || (fit_mode_reg == FIT_BEST  && gap < best_gap_reg)
                     || (fit_mode_reg == FIT_WORST && gap > best_gap_reg);
        region_end = {1'b0, scan_entry.start} + {1'b0, scan_entry.length};
    end

    always_comb
    begin
        new_entry.valid  = 1'b1;
        new_entry.kind   = kind_reg;
        new_entry.start  = best_start_reg;
        new_entry.length = size_reg;
    end

    always_comb
    begin
        state_next      = state_reg;
        func_next       = func_reg;
        size_next       = size_reg;
        kind_next       = kind_reg;
        slot_next       = slot_reg;
        i_next          = i_reg;
        prev_end_next   = prev_end_reg;
        found_next      = found_reg;
        best_gap_next   = best_gap_reg;
        best_start_next = best_start_reg;
        best_pos_next   = best_pos_reg;
        status_next     = status_reg;
        start_next      = start_reg;
        done_next       = 1'b0;
        count_next      = count_reg;
        for (int k = 0; k < SLOTS; k++)
        begin
            cell_op[k] = CELL_HOLD;
        end

        case (state_reg)
            S_IDLE:
            begin
                if (start)
                begin
                    func_next  = func;
                    size_next  = alloc_size;
                    kind_next  = (region_kind > KIND_LOGICAL) ? KIND_PRIMARY : region_kind;
                    slot_next  = slot_index;
                    state_next = S_CHECK;
                end
            end
            S_CHECK:
            begin
                start_next = '0;
                if (func_reg == FUNC_FREE)
                begin
                    state_next = S_DONE;
                    if ({30'd0, slot_reg} >= 32'(SLOTS) || !slot_valid)
                    begin
                        status_next = ST_EMPTY;
                    end
                    else
                    begin
                        status_next = ST_OK;
                        // close the hole: every slot from the freed one up takes its upper neighbor
                        for (int k = 0; k < SLOTS; k++)
                        begin
                            if (32'(k) >= {30'd0, slot_reg})
                            begin
                                cell_op[k] = CELL_FROM_UPPER;
                            end
                        end
                    end
                end
                else if (size_reg == '0)
                begin
                    status_next = ST_ZERO;
                    state_next  = S_DONE;
                end
                else if (32'(used) >= 32'(SLOTS))
                begin
                    status_next = ST_FULL;
                    state_next  = S_DONE;
                end
                else if (kind_reg == KIND_EXTENDED && has_ext)
                begin
                    status_next = ST_EXT2;
                    state_next  = S_DONE;
                end
                else if (kind_reg == KIND_LOGICAL && !has_ext)
                begin
                    status_next = ST_NOEXT;
                    state_next  = S_DONE;
                end
                else
                begin
                    prev_end_next = (ADDR_W + 1)'(header_size_reg);
                    found_next    = 1'b0;
                    i_next        = '0;
                    best_gap_next = '0;
                    best_pos_next = '0;
                    state_next    = S_SCAN;
                end
            end
            S_SCAN:
            begin
                if (fits && take)
                begin
                    found_next      = 1'b1;
                    best_gap_next   = gap;
                    best_start_next = prev_end_reg[ADDR_W-1:0];
                    best_pos_next   = i_reg;
                end
                if (scan_inner)
                begin
                    // running end is the largest region end so far
                    if (region_end > prev_end_reg)
                    begin
                        prev_end_next = region_end;
                    end
                    i_next = i_reg + CNT_W'(1);
                end
                else
                begin
                    state_next = S_COMMIT;
                end
            end
            S_COMMIT:
            begin
                state_next = S_DONE;
                if (!found_reg)
                begin
                    status_next = ST_NOSPACE;
                end
                else
                begin
                    status_next = ST_OK;
                    start_next  = best_start_reg;
                    // open a hole at the chosen slot by shifting the upper entries up
                    for (int k = 0; k < SLOTS; k++)
                    begin
                        if (CNT_W'(k) == best_pos_reg)
                        begin
                            cell_op[k] = CELL_LOAD;
                        end
                        else if (CNT_W'(k) > best_pos_reg && CNT_W'(k) <= used)
                        begin
                            cell_op[k] = CELL_FROM_LOWER;
                        end
                    end
                end
            end
            S_DONE:
            begin
                done_next  = 1'b1;
                count_next = COUNT_W'(used);
                state_next = S_IDLE;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_IDLE;
            func_reg       <= 1'b0;
            size_reg       <= '0;
            kind_reg       <= '0;
            slot_reg       <= '0;
            i_reg          <= '0;
            prev_end_reg   <= '0;
            found_reg      <= 1'b0;
            best_gap_reg   <= '0;
            best_start_reg <= '0;
            best_pos_reg   <= '0;
            status_reg     <= '0;
            start_reg      <= '0;
            done_reg       <= 1'b0;
            count_reg      <= '0;
        end
        else
        begin
            state_reg      <= state_next;
            func_reg       <= func_next;
            size_reg       <= size_next;
            kind_reg       <= kind_next;
            slot_reg       <= slot_next;
            i_reg          <= i_next;
            prev_end_reg   <= prev_end_next;
            found_reg      <= found_next;
            best_gap_reg   <= best_gap_next;
            best_start_reg <= best_start_next;
            best_pos_reg   <= best_pos_next;
            status_reg     <= status_next;
            start_reg      <= start_next;
            done_reg       <= done_next;
            count_reg      <= count_next;
        end
    end

    assign busy          = (state_reg != S_IDLE);
    assign done          = done_reg;
    assign status        = status_reg;
    assign start_address = start_reg;
    assign valid_count   = count_reg;

endmodule

`default_nettype wire

[tb/tb_partition_table_fit_allocator.sv]
// Self-checking testbench for the partition table fit allocator.
// Drives allocate and free transactions, checks each result against a fixed value or a shadow table.
// Depends on ptfa_pkg and partition_table_fit_allocator.
`timescale 1ns / 1ps

module tb_partition_table_fit_allocator
    import ptfa_pkg::*;
();

    localparam int SLOTS = DEFAULT_SLOTS;
    localparam logic [ADDR_W-1:0] ADDR_MAX = '1;
    localparam logic [HDR_W-1:0]  HDR_MAX  = '1;
    // Codes the package leaves unnamed: mode three acts as first fit, kind three as primary
    localparam logic [MODE_W-1:0] FIT_SPARE  = 2'd3;
    localparam logic [KIND_W-1:0] KIND_SPARE = 2'd3;
    localparam int NO_IDLE_FROM = 150;
    localparam int NO_IDLE_TO   = 230;
    localparam int PHASES       = 8;

    typedef struct packed {
        logic [STATUS_W-1:0] st;
        logic [ADDR_W-1:0]   addr;
        logic [COUNT_W-1:0]  count;
    } reply_t;

    typedef struct {
        bit                   is_cfg;
        logic [CFG_IDX_W-1:0] reg_idx;
        logic [ADDR_W-1:0]    value;
        logic                 fn;
        logic [KIND_W-1:0]    kind;
        logic [SLOT_W-1:0]    slot;
        bit                   typed;
        reply_t               want;
    } script_row_t;

    logic                 clk;
    logic                 rst_n       = 1'b0;
    logic                 start       = 1'b0;
    logic                 busy;
    logic                 func        = FUNC_ALLOC;
    logic [ADDR_W-1:0]    alloc_size  = '0;
    logic [KIND_W-1:0]    region_kind = KIND_PRIMARY;
    logic [SLOT_W-1:0]    slot_index  = '0;
    logic                 done;
    logic [STATUS_W-1:0]  status;
    logic [ADDR_W-1:0]    start_address;
    logic [COUNT_W-1:0]   valid_count;
    logic                 cfg_valid   = 1'b0;
    logic                 cfg_ready;
    logic [CFG_IDX_W-1:0] cfg_index   = CFG_DISK_SIZE;
    logic [ADDR_W-1:0]    cfg_data    = '0;

    // Shadow of the block: table plus registers
    entry_t            shadow_table [SLOTS];
    logic [ADDR_W-1:0] disk_bytes   = '0;
    logic [MODE_W-1:0] fit_policy   = FIT_FIRST;
    logic [HDR_W-1:0]  header_bytes = '0;

    reply_t      awaited_replies [$];
    script_row_t script [$];
    int          mismatch_count = 0;
    int          sent = 0;

    partition_table_fit_allocator #(.SLOTS(SLOTS)) dut
    (
        .clk           (clk),
        .rst_n         (rst_n),
        .start         (start),
        .busy          (busy),
        .func          (func),
        .alloc_size    (alloc_size),
        .region_kind   (region_kind),
        .slot_index    (slot_index),
        .done          (done),
        .status        (status),
        .start_address (start_address),
        .valid_count   (valid_count),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data)
    );

    always
    begin
        clk = 1'b0;
        #6;
        clk = 1'b1;
        #6;
    end

    initial
    begin
        #5_000_000;
        $display("Simulation FAILED");
        $finish;
    end

    function automatic reply_t place_or_release(input logic fn,
                                                input logic [ADDR_W-1:0] size,
                                                input logic [KIND_W-1:0] kind_in,
                                                input logic [SLOT_W-1:0] slot);
        reply_t            r;
        int                used;
        int                pick_pos;
        bit                has_ext;
        bit                found;
        bit                take;
        longint unsigned   run_end;
        longint unsigned   bound;
        longint unsigned   gap;
        longint unsigned   region_end;
        longint unsigned   pick_start;
        longint unsigned   pick_gap;
        logic [KIND_W-1:0] kind;

        r          = '0;
        used       = 0;
        pick_pos   = 0;
        has_ext    = 1'b0;
        found      = 1'b0;
        take       = 1'b0;
        pick_start = 0;
        pick_gap   = 0;
        run_end    = header_bytes;
        kind       = (kind_in == KIND_SPARE) ? KIND_PRIMARY : kind_in;
        for (int i = 0; i < SLOTS; i++)
        begin
            if (shadow_table[i].valid)
                used++;
            if (shadow_table[i].valid && shadow_table[i].kind == KIND_EXTENDED)
                has_ext = 1'b1;
        end

        if (fn == FUNC_FREE)
        begin
            if (!shadow_table[slot].valid)
                r.st = ST_EMPTY;
            else
            begin
                // close the hole, then clear the top slot
                for (int i = slot; i < SLOTS - 1; i++)
                    shadow_table[i] = shadow_table[i + 1];
                shadow_table[SLOTS - 1] = '0;
                r.st = ST_OK;
            end
        end
        else if (size == '0)
            r.st = ST_ZERO;
        else if (used >= SLOTS)
            r.st = ST_FULL;
        else if (kind == KIND_EXTENDED && has_ext)
            r.st = ST_EXT2;
        else if (kind == KIND_LOGICAL && !has_ext)
            r.st = ST_NOEXT;
        else
        begin
            // gap i lies before entry i; the last one ends at the disk end
            for (int i = 0; i <= used; i++)
            begin
                bound = (i < used) ? shadow_table[i].start : disk_bytes;
                gap   = (bound > run_end) ? bound - run_end : 0;
                if (gap >= size)
                begin
                    if (!found)
                        take = 1'b1;
                    else if (fit_policy == FIT_BEST)
                        take = gap < pick_gap;
                    else if (fit_policy == FIT_WORST)
                        take = gap > pick_gap;
                    else
                        take = 1'b0;
                    if (take)
                    begin
                        found      = 1'b1;
                        pick_gap   = gap;
                        pick_start = run_end;
                        pick_pos   = i;
                    end
                end
                if (i < used)
                begin
                    region_end = longint'(shadow_table[i].start) + shadow_table[i].length;
                    if (region_end > run_end)
                        run_end = region_end;
                end
            end
            if (!found)
                r.st = ST_NOSPACE;
            else
            begin
                for (int i = used; i > pick_pos; i--)
                    shadow_table[i] = shadow_table[i - 1];
                shadow_table[pick_pos].valid  = 1'b1;
                shadow_table[pick_pos].kind   = kind;
                shadow_table[pick_pos].start  = ADDR_W'(pick_start);
                shadow_table[pick_pos].length = size;
                r.st   = ST_OK;
                r.addr = ADDR_W'(pick_start);
            end
        end

        used = 0;
        for (int i = 0; i < SLOTS; i++)
            if (shadow_table[i].valid)
                used++;
        r.count = COUNT_W'(used);
        return r;
    endfunction

    function automatic script_row_t cfg_row(input logic [CFG_IDX_W-1:0] idx,
                                            input logic [ADDR_W-1:0] value);
        script_row_t row;
        row         = '{default: '0};
        row.is_cfg  = 1'b1;
        row.reg_idx = idx;
        row.value   = value;
        return row;
    endfunction

    function automatic script_row_t op_row(input logic fn, input logic [ADDR_W-1:0] size,
                                           input logic [KIND_W-1:0] kind,
                                           input logic [SLOT_W-1:0] slot);
        script_row_t row;
        row       = '{default: '0};
        row.fn    = fn;
        row.value = size;
        row.kind  = kind;
        row.slot  = slot;
        return row;
    endfunction

    function automatic script_row_t known_row(input logic fn, input logic [ADDR_W-1:0] size,
                                              input logic [KIND_W-1:0] kind,
                                              input logic [SLOT_W-1:0] slot,
                                              input logic [STATUS_W-1:0] st,
                                              input logic [ADDR_W-1:0] addr,
                                              input logic [COUNT_W-1:0] count);
        script_row_t row;
        row            = op_row(fn, size, kind, slot);
        row.typed      = 1'b1;
        row.want.st    = st;
        row.want.addr  = addr;
        row.want.count = count;
        return row;
    endfunction

    // Append a row at the end of the stimulus table
    function automatic void add_row(input script_row_t row);
        script.insert(script.size(), row);
    endfunction

    // Append an awaited result behind the ones already in flight
    function automatic void queue_reply(input reply_t r);
        awaited_replies.insert(awaited_replies.size(), r);
    endfunction

    task automatic sender_gap();
        if ((sent < NO_IDLE_FROM || sent >= NO_IDLE_TO) && $urandom_range(0, 99) < 24)
        begin
            start <= 1'b0;
            repeat ($urandom_range(1, 4)) @(posedge clk);
        end
    endtask

    // Hold start high until the block takes the transaction, then predict it
    task automatic issue_request(input script_row_t row);
        reply_t predicted;
        start       <= 1'b1;
        func        <= row.fn;
        alloc_size  <= row.value;
        region_kind <= row.kind;
        slot_index  <= row.slot;
        do
            @(posedge clk);
        while (busy);
        predicted = place_or_release(row.fn, row.value, row.kind, row.slot);
        queue_reply(row.typed ? row.want : predicted);
        sent++;
    endtask

    // Drop start and wait until the block has delivered everything
    task automatic quiesce();
        start <= 1'b0;
        while (awaited_replies.size() != 0)
            @(posedge clk);
        while (busy)
            @(posedge clk);
        repeat (2) @(posedge clk);
    endtask

    // Leaves cfg_valid high; the caller drops it
    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [ADDR_W-1:0] value);
        if ($urandom_range(0, 99) < 24)
        begin
            cfg_valid <= 1'b0;
            repeat ($urandom_range(1, 4)) @(posedge clk);
        end
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        do
            @(posedge clk);
        while (!cfg_ready);
        case (idx)
            CFG_DISK_SIZE:   disk_bytes   = value;
            CFG_FIT_MODE:    fit_policy   = value[MODE_W-1:0];
            CFG_HEADER_SIZE: header_bytes = value[HDR_W-1:0];
            default: ;
        endcase
    endtask

    always @(posedge clk)
    begin : watch_results
        reply_t want;
        if (rst_n && done)
        begin
            if (awaited_replies.size() == 0)
            begin
                $display("%0t: unexpected result: status %0d, start %0d, count %0d",
                         $time, status, start_address, valid_count);
                mismatch_count++;
            end
            else
            begin
                want = awaited_replies.pop_front();
                if (status !== want.st)
                begin
                    $display("%0t: status expected %0d, got %0d", $time, want.st, status);
                    mismatch_count++;
                end
                if (start_address !== want.addr)
                begin
                    $display("%0t: start_address expected %0d, got %0d",
                             $time, want.addr, start_address);
                    mismatch_count++;
                end
                if (valid_count !== want.count)
                begin
                    $display("%0t: valid_count expected %0d, got %0d",
                             $time, want.count, valid_count);
                    mismatch_count++;
                end
            end
        end
    end

    initial
    begin : drive_requests
        script_row_t       row;
        int unsigned       span;
        int unsigned       pick;
        int                phase_items;
        int                guard;
        logic [ADDR_W-1:0] new_disk;
        logic [HDR_W-1:0]  new_hdr;
        logic [MODE_W-1:0] new_mode;

        for (int i = 0; i < SLOTS; i++)
            shadow_table[i] = '0;

        // Empty table, all registers zero
        add_row(known_row(FUNC_ALLOC, '0, KIND_PRIMARY, 2'd0, ST_ZERO, '0, 3'd0));
        add_row(known_row(FUNC_ALLOC, ADDR_MAX, KIND_PRIMARY, 2'd0, ST_NOSPACE, '0, 3'd0));
        add_row(known_row(FUNC_ALLOC, 31'd1, KIND_LOGICAL, 2'd0, ST_NOEXT, '0, 3'd0));
        add_row(known_row(FUNC_FREE, '0, KIND_PRIMARY, 2'd3, ST_EMPTY, '0, 3'd0));
        add_row(cfg_row(CFG_DISK_SIZE, 31'd1000));
        add_row(cfg_row(CFG_FIT_MODE, ADDR_W'(FIT_FIRST)));
        add_row(cfg_row(CFG_HEADER_SIZE, 31'd100));
        // Fill the table, hitting the extended-twice, no-space and full errors on the way, then free
        add_row(known_row(FUNC_ALLOC, 31'd200, KIND_PRIMARY, 2'd0, ST_OK, 31'd100, 3'd1));
        add_row(known_row(FUNC_ALLOC, 31'd100, KIND_EXTENDED, 2'd1, ST_OK, 31'd300, 3'd2));
        add_row(known_row(FUNC_ALLOC, 31'd50, KIND_EXTENDED, 2'd2, ST_EXT2, '0, 3'd2));
        add_row(known_row(FUNC_ALLOC, 31'd50, KIND_LOGICAL, 2'd3, ST_OK, 31'd400, 3'd3));
        add_row(known_row(FUNC_ALLOC, 31'd551, KIND_SPARE, 2'd0, ST_NOSPACE, '0, 3'd3));
        add_row(known_row(FUNC_ALLOC, 31'd550, KIND_SPARE, 2'd0, ST_OK, 31'd450, 3'd4));
        add_row(known_row(FUNC_ALLOC, 31'd1, KIND_PRIMARY, 2'd0, ST_FULL, '0, 3'd4));
        add_row(known_row(FUNC_FREE, '0, KIND_PRIMARY, 2'd1, ST_OK, '0, 3'd3));
        add_row(known_row(FUNC_FREE, '0, KIND_PRIMARY, 2'd3, ST_EMPTY, '0, 3'd3));
        add_row(known_row(FUNC_FREE, '0, KIND_PRIMARY, 2'd0, ST_OK, '0, 3'd2));
        // Policy differences
        add_row(cfg_row(CFG_FIT_MODE, ADDR_W'(FIT_BEST)));
        add_row(op_row(FUNC_ALLOC, 31'd60, KIND_PRIMARY, 2'd0));
        add_row(op_row(FUNC_FREE, '0, KIND_PRIMARY, 2'd2));
        add_row(op_row(FUNC_ALLOC, 31'd200, KIND_EXTENDED, 2'd0));
        add_row(cfg_row(CFG_FIT_MODE, ADDR_W'(FIT_WORST)));
        add_row(op_row(FUNC_ALLOC, 31'd10, KIND_LOGICAL, 2'd0));
        add_row(op_row(FUNC_FREE, '0, KIND_PRIMARY, 2'd3));
        add_row(cfg_row(CFG_FIT_MODE, ADDR_W'(FIT_SPARE)));
        add_row(op_row(FUNC_ALLOC, 31'd5, KIND_PRIMARY, 2'd0));
        add_row(op_row(FUNC_FREE, '0, KIND_PRIMARY, 2'd3));
        // Header beyond every region end, disk at its maximum
        add_row(cfg_row(CFG_HEADER_SIZE, ADDR_W'(HDR_MAX)));
        add_row(cfg_row(CFG_DISK_SIZE, ADDR_MAX));
        add_row(known_row(FUNC_ALLOC, ADDR_MAX, KIND_PRIMARY, 2'd0, ST_NOSPACE, '0, 3'd3));
        add_row(known_row(FUNC_ALLOC, 31'h7FFF_0000, KIND_PRIMARY, 2'd0, ST_OK,
                          31'd65535, 3'd4));

        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (script[i])
        begin
            if (script[i].is_cfg)
            begin
                quiesce();
                write_reg(script[i].reg_idx, script[i].value);
            end
            else
            begin
                if (cfg_valid)
                    cfg_valid <= 1'b0;
                sender_gap();
                issue_request(script[i]);
            end
        end

        for (int phase = 0; phase < PHASES; phase++)
        begin
            case (phase)
                0:
                begin
                    new_disk = ADDR_MAX;
                    new_hdr  = HDR_MAX;
                    new_mode = FIT_WORST;
                end
                1:
                begin
                    new_disk = '0;
                    new_hdr  = '0;
                    new_mode = FIT_BEST;
                end
                default:
                begin
                    new_hdr  = HDR_W'($urandom_range(0, 300));
                    new_disk = ADDR_W'(new_hdr) + ADDR_W'($urandom_range(200, 3000));
                    new_mode = MODE_W'($urandom_range(0, 3));
                end
            endcase
            quiesce();
            write_reg(CFG_DISK_SIZE, new_disk);
            write_reg(CFG_FIT_MODE, ADDR_W'(new_mode));
            write_reg(CFG_HEADER_SIZE, ADDR_W'(new_hdr));
            cfg_valid <= 1'b0;

            phase_items = (phase == 1) ? 20 : 54;
            span = (disk_bytes > header_bytes) ? disk_bytes - header_bytes : 64;
            for (int n = 0; n < phase_items; n++)
            begin
                row    = '{default: '0};
                row.fn = ($urandom_range(0, 99) < 30) ? FUNC_FREE : FUNC_ALLOC;
                pick   = $urandom_range(0, 99);
                if (pick < 6)
                    row.value = '0;
                else if (pick < 11)
                    row.value = ADDR_W'($urandom);
                else if (pick < 14)
                    row.value = ADDR_MAX;
                else
                    row.value = ADDR_W'($urandom_range(1, span / 3 + 1));
                pick = $urandom_range(0, 99);
                if (pick < 50)
                    row.kind = KIND_PRIMARY;
                else if (pick < 70)
                    row.kind = KIND_EXTENDED;
                else if (pick < 90)
                    row.kind = KIND_LOGICAL;
                else
                    row.kind = KIND_SPARE;
                row.slot = SLOT_W'($urandom_range(0, 3));
                sender_gap();
                issue_request(row);
            end
        end

        start <= 1'b0;
        for (guard = 0; guard < 5000 && awaited_replies.size() != 0; guard++)
            @(posedge clk);
        repeat (12) @(posedge clk);
        if (mismatch_count == 0 && awaited_replies.size() == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end

endmodule

[files.f]
design/ptfa_pkg.sv
design/ptfa_cell.sv
design/partition_table_fit_allocator.sv
tb/tb_partition_table_fit_allocator.sv
